@@ hdl/arc_pkg.sv @@
// ----------------------------------------------------------------------------
// arc_pkg
// Shared codes, command type and checksum function for the register front end.
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

    localparam int MEM_ADDR_BITS = 12;

    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [7:0]  IMEM_FLAG_BYTE = 8'h80;
    localparam int          ERR_SHIFT      = 16;
    localparam logic [1:0]  ALERT_MASK     = 2'b11;
    localparam logic [15:0] MEM_ADDR_MASK  = 16'((32'd1 << MEM_ADDR_BITS) - 32'd1);

    localparam logic [2:0] OP_REG_READ  = 3'd0;
    localparam logic [2:0] OP_REG_WRITE = 3'd1;
    localparam logic [2:0] OP_IMEM_WR   = 3'd2;
    localparam logic [2:0] OP_DMEM_WR   = 3'd3;
    localparam logic [2:0] OP_DONE      = 3'd4;

    localparam logic [3:0] REG_INTR_STATE  = 4'd0;
    localparam logic [3:0] REG_INTR_ENABLE = 4'd1;
    localparam logic [3:0] REG_INTR_TEST   = 4'd2;
    localparam logic [3:0] REG_ALERT_TEST  = 4'd3;
    localparam logic [3:0] REG_CMD         = 4'd4;
    localparam logic [3:0] REG_CTRL        = 4'd5;
    localparam logic [3:0] REG_STATUS      = 4'd6;
    localparam logic [3:0] REG_ERR_BITS    = 4'd7;
    localparam logic [3:0] REG_FATAL_CAUSE = 4'd8;
    localparam logic [3:0] REG_INSN_CNT    = 4'd9;
    localparam logic [3:0] REG_LOAD_CRC    = 4'd10;

    localparam logic [2:0] KIND_NOP   = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_LOAD  = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  reg_idx;
        logic        owned;
        logic [15:0] msg_addr;
        logic [31:0] data;
    } t_cmd;

    function automatic logic [31:0] crc32_msg(input logic [31:0] crc, input logic [47:0] msg);
        logic [31:0] c;
        logic        fb;
        c = ~crc;
        for (int j = 0; j < 6; j++) begin
            for (int k = 0; k < 8; k++) begin
                fb = c[0] ^ msg[40 - 8 * j + k];
                c  = (c >> 1) ^ (fb ? CRC_POLY : 32'd0);
            end
        end
        return ~c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/arc_if.sv @@
// ----------------------------------------------------------------------------
// arc_if
// Request and result channels of the register front end.
// ----------------------------------------------------------------------------
`default_nettype none

interface arc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [3:0]  reg_index;
    logic [11:0] mem_word_address;
    logic [31:0] data_word;
    logic        mem_accepted;
    logic        engine_locked;

    modport source (output valid, output operation, output reg_index,
                    output mem_word_address, output data_word, output mem_accepted,
                    output engine_locked, input ready);
    modport sink (input valid, input operation, input reg_index,
                  input mem_word_address, input data_word, input mem_accepted,
                  input engine_locked, output ready);
endinterface

interface arc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        engine_owned;
    logic        intr_done;
    logic        alert;
    logic [31:0] checksum_out;

    modport source (output valid, output read_data, output engine_owned,
                    output intr_done, output alert, output checksum_out, input ready);
    modport sink (input valid, input read_data, input engine_owned,
                  input intr_done, input alert, input checksum_out, output ready);
endinterface

`default_nettype wire

@@ hdl/accel_regs_with_load_crc.sv @@
// ----------------------------------------------------------------------------
// accel_regs_with_load_crc
// Coprocessor register front end with a running load checksum.
// ----------------------------------------------------------------------------
// One request in, one result out, in order. A request is accepted every
// cycle while the two-entry command queue has room; it is stored in a queue
// entry, then executed into the result register. The back end executes one
// command per cycle while results are taken, including the full six-byte
// CRC-32 update of a memory write, so the rate is one request per cycle.
// The result register holds a finished result while the queue takes requests.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_regs_with_load_crc (
    input  logic      i_clk,
    input  logic      i_rst_n,
    arc_in_if.sink    i_in,
    arc_out_if.source o_out
);

    arc_pkg::t_cmd front_cmd;
    arc_pkg::t_cmd queue_cmd;
    logic          push;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;

    arc_front u_front (
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    arc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    arc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (queue_empty),
        .i_cmd         (queue_cmd),
        .o_pop         (pop),
        .o_out         (o_out)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !queue_empty)
        else $error("pop from empty queue");

    a_owned_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.engine_owned |-> o_out.read_data == 32'd0)
        else $error("engine owned access returned data");

    a_idle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && queue_empty && !o_out.valid |-> ##2 o_out.valid)
        else $error("result missing two cycles after idle accept");

endmodule

`default_nettype wire

@@ hdl/arc_front.sv @@
// ----------------------------------------------------------------------------
// arc_front
// Accept requests and classify them into commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_front (
    arc_in_if.sink        i_in,
    input  logic          i_queue_full,
    output logic          o_push,
    output arc_pkg::t_cmd o_cmd
);

    logic        engine_reg;
    logic [15:0] addr16;

    assign i_in.ready = !i_queue_full;
    assign o_push     = i_in.valid && !i_queue_full;

    always_comb begin
        engine_reg = i_in.reg_index inside {arc_pkg::REG_CTRL, arc_pkg::REG_STATUS,
                                            arc_pkg::REG_ERR_BITS, arc_pkg::REG_INSN_CNT};
        addr16 = {4'b0000, i_in.mem_word_address} & arc_pkg::MEM_ADDR_MASK;
        if (i_in.operation == arc_pkg::OP_IMEM_WR) begin
            addr16 = addr16 | {arc_pkg::IMEM_FLAG_BYTE, 8'h00};
        end

        o_cmd          = '0;
        o_cmd.reg_idx  = i_in.reg_index;
        o_cmd.data     = i_in.data_word;
        o_cmd.msg_addr = addr16;
        o_cmd.kind     = arc_pkg::KIND_NOP;

        case (i_in.operation)
            arc_pkg::OP_REG_READ: begin
                o_cmd.kind  = arc_pkg::KIND_READ;
                o_cmd.owned = engine_reg;
            end
            arc_pkg::OP_REG_WRITE: begin
                if (!i_in.engine_locked) begin
                    o_cmd.kind  = arc_pkg::KIND_WRITE;
                    o_cmd.owned = engine_reg;
                end
            end
            arc_pkg::OP_IMEM_WR, arc_pkg::OP_DMEM_WR: begin
                if (i_in.mem_accepted) begin
                    o_cmd.kind = arc_pkg::KIND_LOAD;
                end
            end
            arc_pkg::OP_DONE: begin
                o_cmd.kind = arc_pkg::KIND_DONE;
            end
            default: begin
                o_cmd.kind = arc_pkg::KIND_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/arc_queue.sv @@
// ----------------------------------------------------------------------------
// arc_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  arc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output arc_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    arc_pkg::t_cmd                       r_mem [arc_pkg::QUEUE_DEPTH];
    logic [arc_pkg::QUEUE_PTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [arc_pkg::QUEUE_PTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [arc_pkg::QUEUE_CNT_BITS-1:0]  r_count, n_count;
    logic                                do_push, do_pop;

    localparam logic [arc_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
        arc_pkg::QUEUE_PTR_BITS'(arc_pkg::QUEUE_DEPTH - 1);
    localparam logic [arc_pkg::QUEUE_CNT_BITS-1:0] FULL_CNT =
        arc_pkg::QUEUE_CNT_BITS'(arc_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/arc_back.sv @@
// ----------------------------------------------------------------------------
// arc_back
// Execute commands against the register state and register the result.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_queue_empty,
    input  arc_pkg::t_cmd i_cmd,
    output logic          o_pop,
    arc_out_if.source     o_out
);

    logic        r_pend, n_pend;
    logic        r_enable, n_enable;
    logic [1:0]  r_alert_bits, n_alert_bits;
    logic [15:0] r_fatal, n_fatal;
    logic [31:0] r_crc, n_crc;
    logic [31:0] n_rdata;

    logic        r_out_valid;
    logic [31:0] r_rdata;
    logic        r_owned;
    logic        r_irq;
    logic        r_alert;
    logic [31:0] r_checksum;

    assign o_pop = !i_queue_empty && (!r_out_valid || o_out.ready);

    always_comb begin
        n_pend       = r_pend;
        n_enable     = r_enable;
        n_alert_bits = r_alert_bits;
        n_fatal      = r_fatal;
        n_crc        = r_crc;
        n_rdata      = '0;
        case (i_cmd.kind)
            arc_pkg::KIND_READ: begin
                case (i_cmd.reg_idx)
                    arc_pkg::REG_INTR_STATE:  n_rdata = {31'd0, r_pend};
                    arc_pkg::REG_INTR_ENABLE: n_rdata = {31'd0, r_enable};
                    arc_pkg::REG_FATAL_CAUSE: n_rdata = {16'd0, r_fatal};
                    arc_pkg::REG_LOAD_CRC:    n_rdata = r_crc;
                    default:                  n_rdata = '0;
                endcase
            end
            arc_pkg::KIND_WRITE: begin
                case (i_cmd.reg_idx)
                    arc_pkg::REG_INTR_STATE: begin
                        if (i_cmd.data[0]) n_pend = 1'b0;
                    end
                    arc_pkg::REG_INTR_ENABLE: n_enable = i_cmd.data[0];
                    arc_pkg::REG_INTR_TEST: begin
                        if (i_cmd.data[0]) n_pend = 1'b1;
                    end
                    arc_pkg::REG_ALERT_TEST:
                        n_alert_bits = r_alert_bits | (i_cmd.data[1:0] & arc_pkg::ALERT_MASK);
                    arc_pkg::REG_LOAD_CRC: n_crc = i_cmd.data;
                    default: ;
                endcase
            end
            arc_pkg::KIND_LOAD: begin
                n_crc = arc_pkg::crc32_msg(r_crc, {i_cmd.msg_addr, i_cmd.data});
            end
            arc_pkg::KIND_DONE: begin
                n_fatal = r_fatal | 16'(i_cmd.data >> arc_pkg::ERR_SHIFT);
                n_pend  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 1'b0;
            r_enable     <= 1'b0;
            r_alert_bits <= '0;
            r_fatal      <= '0;
            r_crc        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pend       <= n_pend;
                r_enable     <= n_enable;
                r_alert_bits <= n_alert_bits;
                r_fatal      <= n_fatal;
                r_crc        <= n_crc;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdata    <= n_rdata;
            r_owned    <= i_cmd.owned;
            r_irq      <= n_pend & n_enable;
            r_alert    <= (n_alert_bits != '0) || (n_fatal != '0);
            r_checksum <= n_crc;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_rdata;
    assign o_out.engine_owned = r_owned;
    assign o_out.intr_done    = r_irq;
    assign o_out.alert        = r_alert;
    assign o_out.checksum_out = r_checksum;

endmodule

`default_nettype wire
